>>> rtl/core/ttlc_pkg.sv
// ttlc_pkg: shared types, codes and defaults for the TTL LRU credential cache.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package ttlc_pkg;

  localparam int DEF_CACHE_DEPTH = 16;
  localparam int DEF_GEN_DEPTH   = 16;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TTL_SECONDS = 2'd1;

  localparam logic [4:0]  LIMIT_RESET  = 5'd16;
  localparam logic [31:0] TTL_RESET    = 32'd3600;
  localparam logic [32:0] SKEW_SECONDS = 33'd30;

  localparam logic [2:0] CMD_GET     = 3'd0;
  localparam logic [2:0] CMD_GET_GEN = 3'd1;
  localparam logic [2:0] CMD_GEN_CUR = 3'd2;
  localparam logic [2:0] CMD_PUT     = 3'd3;
  localparam logic [2:0] CMD_INVAL   = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MISS     = 3'd1;
  localparam logic [2:0] ST_EXPIRED  = 3'd2;
  localparam logic [2:0] ST_REJECTED = 3'd3;
  localparam logic [2:0] ST_STALE    = 3'd4;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] key;
    logic [63:0] value;
    logic        has_provider_expiry;
    logic [31:0] provider_expiry;
    logic        has_expected_gen;
    logic [31:0] expected_gen;
    logic [31:0] now_seconds;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] out_value;
    logic [31:0] out_gen;
    logic [31:0] out_expiry;
    logic        is_current;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_RESP
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic exec;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
  } dp_sts_t;

endpackage

>>> rtl/core/ttlc_ctrl.sv
// ttlc_ctrl: transaction sequencer (idle, scan, execute, respond) and output valid.
// Depends on ttlc_pkg; drives the command struct of ttlc_dp.
`timescale 1ns / 1ps
module ttlc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output ttlc_pkg::ctrl_cmd_t cmd,
  input  ttlc_pkg::dp_sts_t   sts
);
  import ttlc_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> rtl/core/ttlc_dp.sv
// ttlc_dp: cache and generation stores, key walk, LRU rank cells, config registers.
// Depends on ttlc_pkg; sequenced by ttlc_ctrl.
`timescale 1ns / 1ps
module ttlc_dp #(
  parameter int CACHE_DEPTH = ttlc_pkg::DEF_CACHE_DEPTH,
  parameter int GEN_DEPTH   = ttlc_pkg::DEF_GEN_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ttlc_pkg::ctrl_cmd_t                cmd,
  output ttlc_pkg::dp_sts_t                  sts,
  input  ttlc_pkg::in_item_t                 in_data,
  output ttlc_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  input  logic [ttlc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                        cfg_data
);
  import ttlc_pkg::*;

  localparam int CIW    = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int GIW    = (GEN_DEPTH > 1) ? $clog2(GEN_DEPTH) : 1;
  localparam int LW     = $clog2(CACHE_DEPTH + 1);
  localparam int XW     = LW + CIW;
  localparam int CMPW   = (LW > 5) ? LW : 5;
  localparam int SCAN_N = (CACHE_DEPTH > GEN_DEPTH) ? CACHE_DEPTH : GEN_DEPTH;
  localparam int SW     = $clog2(SCAN_N + 1);

  // config
  logic [4:0]  limit_r;
  logic [31:0] ttl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
      ttl_r   <= TTL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ENTRY_LIMIT: limit_r <= cfg_data[4:0];
        CFG_TTL_SECONDS: ttl_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // stores
  logic [63:0] ckey_mem [CACHE_DEPTH];
  logic [63:0] cval_mem [CACHE_DEPTH];
  logic [31:0] cexp_mem [CACHE_DEPTH];
  logic [63:0] gkey_mem [GEN_DEPTH];
  logic [31:0] gcnt_mem [GEN_DEPTH];
  logic [63:0] ckey_q, cval_q, gkey_q;
  logic [31:0] cexp_q, gcnt_q;

  logic [CACHE_DEPTH-1:0] valid_r, valid_nxt;
  logic [CIW-1:0]         rank_r [CACHE_DEPTH];
  logic [CIW-1:0]         rank_nxt [CACHE_DEPTH];
  logic [LW-1:0]          cnt_r, cnt_nxt;
  logic [GEN_DEPTH-1:0]   gvalid_r, gvalid_nxt;
  logic [GIW-1:0]         gnext_r, gnext_nxt;

  // walk and lookup results
  in_item_t       item_r;
  logic [SW-1:0]  sc_r, rd_idx_r;
  logic           rd_v_r;
  logic           chit_r, ghit_r, free_r;
  logic [CIW-1:0] hidx_r, fidx_r, hrank_r;
  logic [GIW-1:0] gidx_r;
  logic [63:0]    hval_r;
  logic [31:0]    hexp_r, gcnt_r;
  out_item_t      res_r, res_nxt, out_r;

  logic           cwe, gwe;
  logic [CIW-1:0] caddr, sc_c, rd_c;
  logic [GIW-1:0] gaddr, sc_g, rd_g;
  logic [31:0]    gcnt_w;

  logic [LW-1:0]  lim;
  logic           evict_cond;
  logic           chit_now, ghit_now, free_now;
  logic [32:0]    now30, sum_ttl, exp33;
  logic [31:0]    exp32;
  logic           put_short, put_stale, get_expired;

  assign sc_c = sc_r[CIW-1:0];
  assign sc_g = sc_r[GIW-1:0];
  assign rd_c = rd_idx_r[CIW-1:0];
  assign rd_g = rd_idx_r[GIW-1:0];

  assign lim = (CMPW'(limit_r) > CMPW'(CACHE_DEPTH)) ? LW'(CACHE_DEPTH) : LW'(limit_r);
  assign evict_cond = (cnt_r >= lim);

  assign chit_now = rd_v_r && (rd_idx_r < SW'(CACHE_DEPTH)) && valid_r[rd_c]
                    && (ckey_q == item_r.key);
  assign ghit_now = rd_v_r && (rd_idx_r < SW'(GEN_DEPTH)) && gvalid_r[rd_g]
                    && (gkey_q == item_r.key);
  assign free_now = (sc_r < SW'(CACHE_DEPTH)) && (!valid_r[sc_c] || (evict_cond &&
                    ((XW'(rank_r[sc_c]) + XW'(1)) >= XW'(lim))));

  assign sts.scan_done = (sc_r == SW'(SCAN_N));

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r     <= '0;
      rd_idx_r <= '0;
      rd_v_r   <= 1'b0;
      chit_r   <= 1'b0;
      ghit_r   <= 1'b0;
      free_r   <= 1'b0;
    end else if (cmd.load) begin
      sc_r   <= '0;
      rd_v_r <= 1'b0;
      chit_r <= 1'b0;
      ghit_r <= 1'b0;
      free_r <= 1'b0;
    end else if (cmd.scan) begin
      sc_r     <= sc_r + SW'(1);
      rd_idx_r <= sc_r;
      rd_v_r   <= 1'b1;
      if (chit_now && !chit_r) begin
        chit_r  <= 1'b1;
        hidx_r  <= rd_c;
        hrank_r <= rank_r[rd_c];
        hval_r  <= cval_q;
        hexp_r  <= cexp_q;
      end
      if (ghit_now && !ghit_r) begin
        ghit_r <= 1'b1;
        gidx_r <= rd_g;
        gcnt_r <= gcnt_q;
      end
      if (free_now && !free_r) begin
        free_r <= 1'b1;
        fidx_r <= sc_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cwe) begin
      ckey_mem[caddr] <= item_r.key;
      cval_mem[caddr] <= item_r.value;
      cexp_mem[caddr] <= exp32;
    end
    ckey_q <= ckey_mem[sc_c];
    cval_q <= cval_mem[sc_c];
    cexp_q <= cexp_mem[sc_c];
  end

  always_ff @(posedge clk) begin
    if (gwe) begin
      gkey_mem[gaddr] <= item_r.key;
      gcnt_mem[gaddr] <= gcnt_w;
    end
    gkey_q <= gkey_mem[sc_g];
    gcnt_q <= gcnt_mem[sc_g];
  end

  // time arithmetic, 33 bits so nothing wraps
  assign now30   = {1'b0, item_r.now_seconds} + SKEW_SECONDS;
  assign sum_ttl = {1'b0, item_r.now_seconds} + {1'b0, ttl_r};
  assign exp33   = (item_r.has_provider_expiry && ({1'b0, item_r.provider_expiry} < sum_ttl))
                   ? {1'b0, item_r.provider_expiry} : sum_ttl;
  assign exp32   = exp33[32] ? 32'hFFFF_FFFF : exp33[31:0];
  assign put_short   = ({1'b0, exp32} <= now30);
  assign put_stale   = item_r.has_expected_gen &&
                       (!ghit_r || (gcnt_r != item_r.expected_gen));
  assign get_expired = (now30 >= {1'b0, hexp_r});

  always_comb begin
    logic do_touch, do_remove, do_insert;
    logic [GIW-1:0] gadv;
    do_touch   = 1'b0;
    do_remove  = 1'b0;
    do_insert  = 1'b0;
    gadv       = (gnext_r == GIW'(GEN_DEPTH - 1)) ? '0 : gnext_r + GIW'(1);
    valid_nxt  = valid_r;
    rank_nxt   = rank_r;
    cnt_nxt    = cnt_r;
    gvalid_nxt = gvalid_r;
    gnext_nxt  = gnext_r;
    cwe        = 1'b0;
    caddr      = hidx_r;
    gwe        = 1'b0;
    gaddr      = gidx_r;
    gcnt_w     = gcnt_r;
    res_nxt    = res_r;
    if (cmd.exec) begin
      res_nxt.status     = ST_OK;
      res_nxt.out_value  = '0;
      res_nxt.out_gen    = ghit_r ? gcnt_r : '0;
      res_nxt.out_expiry = '0;
      res_nxt.is_current = 1'b0;
      case (item_r.cmd)
        CMD_GET: begin
          if (!chit_r) begin
            res_nxt.status = ST_MISS;
          end else if (get_expired) begin
            res_nxt.status = ST_EXPIRED;
            do_remove      = 1'b1;
          end else begin
            do_touch          = 1'b1;
            res_nxt.out_value = hval_r;
          end
        end
        CMD_GET_GEN: begin
          if (!ghit_r) begin
            gwe                 = 1'b1;
            gaddr               = gnext_r;
            gcnt_w              = '0;
            gvalid_nxt[gnext_r] = 1'b1;
            gnext_nxt           = gadv;
          end
        end
        CMD_GEN_CUR: begin
          res_nxt.is_current = ghit_r && item_r.has_expected_gen &&
                               (gcnt_r == item_r.expected_gen);
        end
        CMD_PUT: begin
          if (lim == '0 || put_short) begin
            res_nxt.status = ST_REJECTED;
          end else if (put_stale) begin
            res_nxt.status = ST_STALE;
          end else begin
            res_nxt.out_expiry = exp32;
            if (chit_r) begin
              cwe      = 1'b1;
              caddr    = hidx_r;
              do_touch = 1'b1;
            end else if (free_r) begin
              cwe       = 1'b1;
              caddr     = fidx_r;
              do_insert = 1'b1;
            end
          end
        end
        CMD_INVAL: begin
          gwe = 1'b1;
          if (ghit_r) begin
            gaddr  = gidx_r;
            gcnt_w = gcnt_r + 32'd1;
          end else begin
            gaddr               = gnext_r;
            gcnt_w              = 32'd1;
            gvalid_nxt[gnext_r] = 1'b1;
            gnext_nxt           = gadv;
          end
          res_nxt.out_gen = gcnt_w;
          do_remove       = chit_r;
        end
        default: res_nxt.status = ST_REJECTED;
      endcase
    end

    // rank cells
    for (int j = 0; j < CACHE_DEPTH; j++) begin
      if (do_touch) begin
        if (valid_r[j] && (rank_r[j] < hrank_r)) rank_nxt[j] = rank_r[j] + CIW'(1);
        if (CIW'(j) == hidx_r) rank_nxt[j] = '0;
      end
      if (do_remove) begin
        if (valid_r[j] && (rank_r[j] > hrank_r)) rank_nxt[j] = rank_r[j] - CIW'(1);
        if (CIW'(j) == hidx_r) begin
          valid_nxt[j] = 1'b0;
          rank_nxt[j]  = '0;
        end
      end
      if (do_insert) begin
        if (valid_r[j] && evict_cond && ((XW'(rank_r[j]) + XW'(1)) >= XW'(lim))) begin
          valid_nxt[j] = 1'b0;
          rank_nxt[j]  = '0;
        end else if (valid_r[j]) begin
          rank_nxt[j] = rank_r[j] + CIW'(1);
        end
        if (CIW'(j) == fidx_r) begin
          valid_nxt[j] = 1'b1;
          rank_nxt[j]  = '0;
        end
      end
    end
    if (do_remove) cnt_nxt = cnt_r - LW'(1);
    if (do_insert) cnt_nxt = evict_cond ? lim : cnt_r + LW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      cnt_r    <= '0;
      gvalid_r <= '0;
      gnext_r  <= '0;
      for (int j = 0; j < CACHE_DEPTH; j++) rank_r[j] <= '0;
    end else begin
      valid_r  <= valid_nxt;
      rank_r   <= rank_nxt;
      cnt_r    <= cnt_nxt;
      gvalid_r <= gvalid_nxt;
      gnext_r  <= gnext_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (cmd.out_load) out_r <= res_r;
  end

  assign out_data = out_r;

endmodule

>>> rtl/core/ttl_lru_cache_with_generation_fence_top.sv
// Top level of the TTL LRU credential cache with invalidation generation fence.
// Depends on ttlc_pkg, ttlc_ctrl and ttlc_dp.
//
// One transaction at a time: an accepted command walks the cache key store and the
// generation key store together, one entry per cycle through their registered read
// ports, then updates state in the execute step. The result is registered into the
// output in the respond state once the output is not stalled, and the next command is
// taken once the sequencer is back in idle, while a previous result may still wait at
// the output. Configuration writes are always ready and take effect at once.
`timescale 1ns / 1ps
module ttl_lru_cache_with_generation_fence_top #(
  parameter int CACHE_DEPTH = ttlc_pkg::DEF_CACHE_DEPTH,
  parameter int GEN_DEPTH   = ttlc_pkg::DEF_GEN_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ttlc_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ttlc_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ttlc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);
  import ttlc_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  assign cfg_ready = 1'b1;

  ttlc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  ttlc_dp #(
    .CACHE_DEPTH (CACHE_DEPTH),
    .GEN_DEPTH   (GEN_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second transaction taken while one is in flight");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status <= ST_STALE))
    else $error("result status out of range");

  a_current_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.is_current) |-> (out_data.status == ST_OK))
    else $error("generation match with non-ok status");

  a_expiry_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.out_expiry != 32'd0)) |-> (out_data.status == ST_OK))
    else $error("expiry reported on failed put");

endmodule
